@@ rtl/voxel_grid_sphere_editor_core_assert.svh @@
`ifndef VOXEL_GRID_SPHERE_EDITOR_CORE_ASSERT_SVH
`define VOXEL_GRID_SPHERE_EDITOR_CORE_ASSERT_SVH

// Concurrent check that is switched off while the asynchronous reset is low.
`define VGSE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Concurrent check that also holds while reset is applied.
`define VGSE_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/vgse_pkg.sv @@
package vgse_pkg;

	localparam int MAX_DIM_DEFAULT = 32;

	localparam int CMD_W     = 4;
	localparam int COORD_W   = 8;
	localparam int SIZE_W    = 6;
	localparam int CFG_IDX_W = 2;

	// Squared distance along one axis between two 8-bit coordinates.
	localparam int SQW = 2 * COORD_W;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ       = 4'd0,
		CMD_SET        = 4'd1,
		CMD_CLEAR      = 4'd2,
		CMD_TOGGLE     = 4'd3,
		CMD_SPH_SET    = 4'd4,
		CMD_SPH_CLEAR  = 4'd5,
		CMD_SPH_TOGGLE = 4'd6,
		CMD_FILL       = 4'd7,
		CMD_CLEAR_ALL  = 4'd8
	} command_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIZE_X = 2'd0,
		REG_SIZE_Y = 2'd1,
		REG_SIZE_Z = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADDR1,
		ST_ADDR2,
		ST_READ,
		ST_SETUP,
		ST_WALK,
		ST_DRAIN,
		ST_RESP
	} state_t;

endpackage

@@ rtl/vgse_if.sv @@
interface vgse_cmd_if import vgse_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [COORD_W-1:0] pos_x;
	logic [COORD_W-1:0] pos_y;
	logic [COORD_W-1:0] pos_z;
	logic [COORD_W-1:0] radius;

	modport source (output valid, command, pos_x, pos_y, pos_z, radius, input ready);
	modport sink (input valid, command, pos_x, pos_y, pos_z, radius, output ready);
endinterface

interface vgse_res_if ();
	logic valid;
	logic ready;
	logic voxel_value;
	logic out_of_range;

	modport source (output valid, voxel_value, out_of_range, input ready);
	modport sink (input valid, voxel_value, out_of_range, output ready);
endinterface

@@ rtl/vgse_ram.sv @@
module vgse_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/voxel_grid_sphere_editor_core.sv @@
// Voxel grid sphere editor. The block keeps a one-bit occupancy map of up to
// MAX_DIM x MAX_DIM x MAX_DIM voxels in a single synchronous RAM, laid out as
// x*size_y*size_z + y*size_z + z under the current sizes (a size above MAX_DIM
// counts as MAX_DIM). Each command item yields exactly one result item. A
// single-voxel command forms the address through two registered
// multiplications, then makes one read and, unless it is a read, one
// write-back on the RAM ports. Sphere, fill and clear-all commands walk the
// whole grid, one voxel per cycle, reading each voxel while the previous
// one is written back, so the single RAM read port sets the pace.
// Squared distances are kept incrementally per axis, so the walk itself needs
// no multiplier; before a sphere walk, set-up steps square the three centre
// coordinates and the radius in turn with one shared multiplier. After reset
// the RAM is swept to zero, one entry per cycle, over all MAX_DIM^3 entries
// (32768 at the default); no command is taken during the sweep, but the size
// registers may be written. The result sits in an output register, so the
// next command can be taken while it waits. Sizes must only be written while
// the block is idle.
module voxel_grid_sphere_editor_core import vgse_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIZE_W-1:0]    cfg_data,
	vgse_cmd_if.sink             cmd,
	vgse_res_if.source           result
);

	localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_DIM);
	localparam int DW    = $clog2(MAX_DIM + 1);
	localparam int P1W   = $clog2(MAX_DIM * MAX_DIM);
	localparam int SUMW  = SQW + 2;

	// Set-up steps of the shared squarer.
	localparam logic [1:0] SQ_CX = 2'd0;
	localparam logic [1:0] SQ_CY = 2'd1;
	localparam logic [1:0] SQ_CZ = 2'd2;
	localparam logic [1:0] SQ_R  = 2'd3;

	// Extent used along one axis: the register value, limited to MAX_DIM.
	function automatic logic [DW-1:0] eff_dim(input logic [SIZE_W-1:0] s);
		return (int'(s) > MAX_DIM) ? DW'(MAX_DIM) : DW'(s);
	endfunction

	// (p+1-c)^2 from (p-c)^2. The true result fits SQW bits, so the
	// arithmetic modulo 2^SQW is exact.
	function automatic logic [SQW-1:0] sq_next(input logic [SQW-1:0] sq,
			input logic [CW-1:0] p, input logic [COORD_W-1:0] c);
		return sq + SQW'({p, 1'b1}) - SQW'({c, 1'b0});
	endfunction

	// Bit written back for a voxel that the command touches.
	function automatic logic new_bit(input logic [CMD_W-1:0] c, input logic old);
		logic b;
		b = 1'b0;
		unique case (c) inside
			CMD_SET, CMD_SPH_SET, CMD_FILL: b = 1'b1;
			CMD_TOGGLE, CMD_SPH_TOGGLE:     b = ~old;
			default:                        b = 1'b0;
		endcase
		return b;
	endfunction

	state_t state_q, state_d;

	logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
	logic [DW-1:0]     dim_x, dim_y, dim_z;

	// Command held for the length of its work.
	logic [CMD_W-1:0]   cmd_q;
	logic [COORD_W-1:0] cx_q, cy_q, cz_q, rad_q;
	logic               value_q, oor_q;

	// Address generation and walk counters.
	logic [AW-1:0]  addr_q;
	logic [P1W-1:0] p1_q;
	logic [CW-1:0]  x_q, y_q, z_q;
	logic [1:0]     sq_cnt_q;

	// Per-axis squared distances and the squared radius.
	logic [SQW-1:0]  sq_x_q, sq_y_q, sq_z_q, base_y_q, base_z_q, r2_q;
	logic [COORD_W-1:0] sq_op;
	logic [SQW-1:0]  sq_val;
	logic [SUMW-1:0] dist2;

	// Read-modify-write stage: the voxel whose old bit arrives from the RAM.
	logic          valid_s1, hit_s1;
	logic [AW-1:0] addr_s1;

	// Output register.
	logic out_valid_q, out_value_q, out_oor_q;

	// Decode of the offered command.
	logic is_single, is_sphere, is_bulk, in_outside, grid_empty;
	logic accept, bulk_op;
	logic x_end, y_end, z_end, walk_last, clear_last;

	// Control outputs.
	logic          issue, issue_hit, out_load, out_free;
	logic          ram_we, ram_wd, ram_rd;
	logic [AW-1:0] ram_wa;

	assign dim_x = eff_dim(size_x_q);
	assign dim_y = eff_dim(size_y_q);
	assign dim_z = eff_dim(size_z_q);

	assign grid_empty = (dim_x == '0) || (dim_y == '0) || (dim_z == '0);
	assign in_outside = (cmd.pos_x >= COORD_W'(dim_x)) || (cmd.pos_y >= COORD_W'(dim_y)) ||
		(cmd.pos_z >= COORD_W'(dim_z));

	always_comb begin
		is_single = 1'b0;
		is_sphere = 1'b0;
		is_bulk   = 1'b0;
		unique case (cmd.command) inside
			CMD_READ, CMD_SET, CMD_CLEAR, CMD_TOGGLE: is_single = 1'b1;
			CMD_SPH_SET, CMD_SPH_CLEAR, CMD_SPH_TOGGLE: is_sphere = 1'b1;
			CMD_FILL, CMD_CLEAR_ALL: is_bulk = 1'b1;
			default: ;
		endcase
	end

	assign accept  = cmd.valid && cmd.ready;
	assign bulk_op = (cmd_q == CMD_FILL) || (cmd_q == CMD_CLEAR_ALL);

	assign x_end      = (DW'(x_q) == dim_x - DW'(1));
	assign y_end      = (DW'(y_q) == dim_y - DW'(1));
	assign z_end      = (DW'(z_q) == dim_z - DW'(1));
	assign walk_last  = x_end && y_end && z_end;
	assign clear_last = (addr_q == AW'(DEPTH - 1));

	assign dist2 = SUMW'(sq_x_q) + SUMW'(sq_y_q) + SUMW'(sq_z_q);

	// One squarer serves the centre coordinates and the radius in turn.
	always_comb begin
		unique case (sq_cnt_q)
			SQ_CX:   sq_op = cx_q;
			SQ_CY:   sq_op = cy_q;
			SQ_CZ:   sq_op = cz_q;
			SQ_R:    sq_op = rad_q;
			default: sq_op = rad_q;
		endcase
	end
	assign sq_val = SQW'(sq_op) * SQW'(sq_op);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd.valid) begin
					if (is_single) begin
						state_d = in_outside ? ST_RESP : ST_ADDR1;
					end else if (is_sphere) begin
						state_d = grid_empty ? ST_RESP : ST_SETUP;
					end else if (is_bulk) begin
						state_d = grid_empty ? ST_RESP : ST_WALK;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_ADDR1: state_d = ST_ADDR2;
			ST_ADDR2: state_d = ST_READ;
			ST_READ:  state_d = ST_DRAIN;
			ST_SETUP: begin
				if (sq_cnt_q == SQ_R) state_d = ST_WALK;
			end
			ST_WALK: begin
				if (walk_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_RESP;
			ST_RESP: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		issue     = 1'b0;
		issue_hit = 1'b0;
		out_free  = !out_valid_q || result.ready;
		out_load  = 1'b0;
		ram_we    = 1'b0;
		ram_wa    = addr_s1;
		ram_wd    = new_bit(cmd_q, ram_rd);
		unique case (state_q)
			ST_READ: begin
				issue     = 1'b1;
				issue_hit = 1'b1;
			end
			ST_WALK: begin
				issue     = 1'b1;
				issue_hit = bulk_op || (dist2 < SUMW'(r2_q));
			end
			ST_RESP: out_load = out_free;
			default: ;
		endcase
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
			ram_wa = addr_q;
			ram_wd = 1'b0;
		end else begin
			ram_we = valid_s1 && hit_s1 && (cmd_q != CMD_READ);
		end
	end

	assign cmd.ready           = (state_q == ST_IDLE);
	assign result.valid        = out_valid_q;
	assign result.voxel_value  = out_value_q;
	assign result.out_of_range = out_oor_q;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			addr_q      <= '0;
			sq_cnt_q    <= SQ_CX;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			size_x_q    <= SIZE_RESET;
			size_y_q    <= SIZE_RESET;
			size_z_q    <= SIZE_RESET;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;

			unique case (state_q)
				ST_CLEAR: addr_q <= addr_q + AW'(1);
				ST_IDLE:  addr_q <= '0;
				ST_ADDR2: addr_q <= AW'(p1_q) * AW'(dim_z) + AW'(cz_q[CW-1:0]);
				ST_WALK:  addr_q <= addr_q + AW'(1);
				default: ;
			endcase

			if (state_q == ST_SETUP) begin
				sq_cnt_q <= sq_cnt_q + 2'd1;
			end else begin
				sq_cnt_q <= SQ_CX;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_wr_en) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_SIZE_X: size_x_q <= cfg_data;
					REG_SIZE_Y: size_y_q <= cfg_data;
					REG_SIZE_Z: size_z_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		hit_s1  <= issue_hit;
		addr_s1 <= addr_q;

		if (accept) begin
			cmd_q   <= cmd.command;
			cx_q    <= cmd.pos_x;
			cy_q    <= cmd.pos_y;
			cz_q    <= cmd.pos_z;
			rad_q   <= cmd.radius;
			value_q <= 1'b0;
			oor_q   <= is_single && in_outside;
			x_q     <= '0;
			y_q     <= '0;
			z_q     <= '0;
		end

		if (state_q == ST_ADDR1) begin
			p1_q <= P1W'(cx_q[CW-1:0]) * P1W'(dim_y) + P1W'(cy_q[CW-1:0]);
		end

		if (state_q == ST_SETUP) begin
			unique case (sq_cnt_q)
				SQ_CX: sq_x_q <= sq_val;
				SQ_CY: begin
					sq_y_q   <= sq_val;
					base_y_q <= sq_val;
				end
				SQ_CZ: begin
					sq_z_q   <= sq_val;
					base_z_q <= sq_val;
				end
				SQ_R:    r2_q <= sq_val;
				default: ;
			endcase
		end

		// The walk runs z fastest, then y, then x, matching the memory layout.
		if (state_q == ST_WALK) begin
			if (z_end) begin
				z_q    <= '0;
				sq_z_q <= base_z_q;
				if (y_end) begin
					y_q    <= '0;
					sq_y_q <= base_y_q;
					if (!x_end) begin
						x_q    <= x_q + CW'(1);
						sq_x_q <= sq_next(sq_x_q, x_q, cx_q);
					end
				end else begin
					y_q    <= y_q + CW'(1);
					sq_y_q <= sq_next(sq_y_q, y_q, cy_q);
				end
			end else begin
				z_q    <= z_q + CW'(1);
				sq_z_q <= sq_next(sq_z_q, z_q, cz_q);
			end
		end

		if (valid_s1 && hit_s1 && (cmd_q == CMD_READ)) begin
			value_q <= ram_rd;
		end

		if (out_load) begin
			out_value_q <= value_q;
			out_oor_q   <= oor_q;
		end
	end

	vgse_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_wa),
		.wr_data (ram_wd),
		.rd_en   (issue),
		.rd_addr (addr_q),
		.rd_data (ram_rd)
	);

endmodule

@@ rtl/vgse_checker.sv @@
`include "voxel_grid_sphere_editor_core_assert.svh"

module vgse_checker (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic result_valid,
	input logic result_ready,
	input logic voxel_value,
	input logic out_of_range
);

	// No result is offered while reset is applied.
	`VGSE_ASSERT_ALWAYS(a_no_result_in_reset, !arst_n |-> !result_valid, "result offered during reset")

	// A bit is only read back from inside the grid, so both flags never show together.
	`VGSE_ASSERT(a_flags_exclusive, result_valid |-> !(voxel_value && out_of_range), "voxel_value and out_of_range both set")

	// Once a command is accepted, ready drops, so commands are never taken back to back.
	`VGSE_ASSERT(a_busy_after_accept, cmd_valid && cmd_ready |=> !cmd_ready, "command taken in back-to-back cycles")

	// A result that is not taken stays unchanged.
	`VGSE_ASSERT(a_result_held, result_valid && !result_ready |=> result_valid && $stable(voxel_value) && $stable(out_of_range), "stalled result changed")

endmodule

bind voxel_grid_sphere_editor_core vgse_checker u_vgse_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_valid    (cmd.valid),
	.cmd_ready    (cmd.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.voxel_value  (result.voxel_value),
	.out_of_range (result.out_of_range)
);
